>>> sv/c2d_pkg.sv
package c2d_pkg;

    localparam int MAX_HEIGHT       = 32;
    localparam int MAX_WIDTH        = 32;
    localparam int MAX_IN_CHANNELS  = 4;
    localparam int MAX_OUT_CHANNELS = 8;
    localparam int MAX_KERNEL       = 5;
    localparam int IMG_DEPTH        = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int TAPS_PER_OUT     = MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int WGT_DEPTH        = MAX_OUT_CHANNELS * TAPS_PER_OUT;
    localparam int IMG_AW           = $clog2(IMG_DEPTH);
    localparam int WGT_AW           = $clog2(WGT_DEPTH);

    typedef enum logic [1:0] {
        REQ_WR_WEIGHT = 2'd0,
        REQ_WR_BIAS   = 2'd1,
        REQ_WR_PIXEL  = 2'd2,
        REQ_COMPUTE   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        CFG_IMG_H  = 3'd0,
        CFG_IMG_W  = 3'd1,
        CFG_IN_CH  = 3'd2,
        CFG_KER_H  = 3'd3,
        CFG_KER_W  = 3'd4,
        CFG_STRIDE = 3'd5,
        CFG_PAD_R  = 3'd6,
        CFG_PAD_C  = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP1,
        ST_SETUP2,
        ST_RUN,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [5:0] img_h;
        logic [5:0] img_w;
        logic [2:0] in_ch;
        logic [2:0] ker_h;
        logic [2:0] ker_w;
        logic [2:0] stride;
        logic [2:0] pad_r;
        logic [2:0] pad_c;
    } t_cfg;

    typedef struct packed {
        logic latch;
        logic wr;
        logic setup1;
        logic setup2;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic range_bad;
        logic last_tap;
        logic out_busy;
    } t_sts;

    // Saturate a register value into [lo, hi]
    function automatic logic [5:0] clamp_val(logic [5:0] v, logic [5:0] lo, logic [5:0] hi);
        logic [5:0] r;
        r = v;
        if (v < lo) r = lo;
        if (v > hi) r = hi;
        return r;
    endfunction

endpackage

>>> sv/c2d_ctrl.sv
module c2d_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_req_type,
    input  c2d_pkg::t_sts  i_sts,
    output c2d_pkg::t_cmd  o_cmd,
    output logic           o_in_stall
);
    import c2d_pkg::*;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_req_type == REQ_COMPUTE) begin
                        o_cmd.latch = 1'b1;
                        n_state     = ST_SETUP1;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            ST_SETUP1: begin
                o_cmd.setup1 = 1'b1;
                n_state      = ST_SETUP2;
            end
            ST_SETUP2: begin
                o_cmd.setup2 = 1'b1;
                n_state      = i_sts.range_bad ? ST_DONE : ST_RUN;
            end
            ST_RUN: begin
                o_cmd.step = 1'b1;
                if (i_sts.last_tap) n_state = ST_DRAIN1;
            end
            ST_DRAIN1: n_state = ST_DRAIN2;
            ST_DRAIN2: n_state = ST_DONE;
            ST_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

>>> sv/c2d_dpath.sv
module c2d_dpath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  c2d_pkg::t_cfg        i_cfg,
    input  c2d_pkg::t_cmd        i_cmd,
    input  logic [1:0]           i_req_type,
    input  logic [11:0]          i_index,
    input  logic [2:0]           i_out_channel,
    input  logic [4:0]           i_out_row,
    input  logic [4:0]           i_out_col,
    input  logic signed [31:0]   i_data_value,
    input  logic                 i_out_stall,
    output c2d_pkg::t_sts        o_sts,
    output logic                 o_out_valid,
    output logic signed [31:0]   o_out_value,
    output logic                 o_range_error
);
    import c2d_pkg::*;

    logic [7:0]  img_mem [IMG_DEPTH];
    logic [7:0]  wgt_mem [WGT_DEPTH];
    logic [31:0] r_bias [MAX_OUT_CHANNELS];

    logic [2:0]         r_oc;
    logic [4:0]         r_orow, r_ocol;
    logic [7:0]         r_rs, r_cs;
    logic [10:0]        r_hw;
    logic signed [8:0]  r_row0, r_col0, r_row, r_col;
    logic [2:0]         r_kr, r_kc, r_c;
    logic signed [14:0] r_chaddr, r_rowaddr;
    logic [WGT_AW-1:0]  r_wa;
    logic               r_bad;
    logic               r_v1, r_v2;
    logic signed [7:0]  r_pix, r_wgt;
    logic signed [15:0] r_prod;
    logic signed [23:0] r_acc;
    logic               r_ovalid;
    logic signed [31:0] r_oval;
    logic               r_oerr;

    logic signed [8:0]  row0, col0;
    logic signed [14:0] row0w, pa_full;
    logic [8:0]         need_r, have_r, need_c, have_c;
    logic               tap_ok, kc_end, kr_end, c_end;
    logic signed [33:0] total;
    logic signed [31:0] sat;

    // Write-side addressing is bounded by the field widths, weights checked here
    logic               wgt_wr_ok;
    logic [WGT_AW-1:0]  wgt_wr_addr;
    assign wgt_wr_ok   = ({20'd0, i_index} < 32'(TAPS_PER_OUT));
    assign wgt_wr_addr = WGT_AW'(i_out_channel * TAPS_PER_OUT) + WGT_AW'(i_index);

    // Window origin and range check
    assign row0   = $signed({1'b0, r_rs}) - $signed({6'd0, i_cfg.pad_r});
    assign col0   = $signed({1'b0, r_cs}) - $signed({6'd0, i_cfg.pad_c});
    assign row0w  = 15'(row0 * $signed({1'b0, i_cfg.img_w}));
    assign need_r = {1'b0, r_rs} + {6'd0, i_cfg.ker_h};
    assign have_r = {3'd0, i_cfg.img_h} + {5'd0, i_cfg.pad_r, 1'b0};
    assign need_c = {1'b0, r_cs} + {6'd0, i_cfg.ker_w};
    assign have_c = {3'd0, i_cfg.img_w} + {5'd0, i_cfg.pad_c, 1'b0};

    assign kc_end = (r_kc == i_cfg.ker_w - 3'd1);
    assign kr_end = (r_kr == i_cfg.ker_h - 3'd1);
    assign c_end  = (r_c  == i_cfg.in_ch - 3'd1);

    assign tap_ok = (r_row >= 0) && (r_row < $signed({3'd0, i_cfg.img_h}))
                 && (r_col >= 0) && (r_col < $signed({3'd0, i_cfg.img_w}));
    assign pa_full = r_rowaddr + 15'(r_col);

    assign o_sts.range_bad = (need_r > have_r) || (need_c > have_c);
    assign o_sts.last_tap  = kc_end && kr_end && c_end;
    assign o_sts.out_busy  = r_ovalid && i_out_stall;

    // Store writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            if (i_req_type == REQ_WR_PIXEL)
                img_mem[IMG_AW'(i_index)] <= i_data_value[7:0];
            if (i_req_type == REQ_WR_WEIGHT && wgt_wr_ok)
                wgt_mem[wgt_wr_addr] <= i_data_value[7:0];
            if (i_req_type == REQ_WR_BIAS)
                r_bias[i_out_channel] <= i_data_value;
        end
    end

    // Tap reads
    always_ff @(posedge i_clk) begin
        r_pix <= img_mem[pa_full[IMG_AW-1:0]];
        r_wgt <= wgt_mem[r_wa];
    end

    // Setup and tap walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_oc   <= i_out_channel;
            r_orow <= i_out_row;
            r_ocol <= i_out_col;
        end
        if (i_cmd.setup1) begin
            r_rs <= 8'(r_orow * i_cfg.stride);
            r_cs <= 8'(r_ocol * i_cfg.stride);
            r_hw <= 11'(i_cfg.img_h * i_cfg.img_w);
        end
        if (i_cmd.setup2) begin
            r_row0    <= row0;
            r_col0    <= col0;
            r_row     <= row0;
            r_col     <= col0;
            r_kr      <= '0;
            r_kc      <= '0;
            r_c       <= '0;
            r_chaddr  <= row0w;
            r_rowaddr <= row0w;
            r_wa      <= WGT_AW'(r_oc * TAPS_PER_OUT);
            r_bad     <= o_sts.range_bad;
        end
        if (i_cmd.step) begin
            r_wa <= r_wa + 1'b1;
            if (!kc_end) begin
                r_kc  <= r_kc + 3'd1;
                r_col <= r_col + 9'sd1;
            end else begin
                r_kc  <= '0;
                r_col <= r_col0;
                if (!kr_end) begin
                    r_kr      <= r_kr + 3'd1;
                    r_row     <= r_row + 9'sd1;
                    r_rowaddr <= r_rowaddr + $signed({9'd0, i_cfg.img_w});
                end else begin
                    r_kr      <= '0;
                    r_row     <= r_row0;
                    r_c       <= r_c + 3'd1;
                    r_chaddr  <= r_chaddr + $signed({4'd0, r_hw});
                    r_rowaddr <= r_chaddr + $signed({4'd0, r_hw});
                end
            end
        end
    end

    // Multiply-accumulate pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.step && tap_ok;
            r_v2 <= r_v1;
        end
        r_prod <= r_pix * r_wgt;
        if (i_cmd.setup1)  r_acc <= '0;
        else if (r_v2)     r_acc <= r_acc + 24'(r_prod);
    end

    // Add bias and saturate
    assign total = 34'(r_acc) + 34'($signed(r_bias[r_oc]));
    always_comb begin
        sat = total[31:0];
        if (total > 34'sh7FFFFFFF)       sat = 32'sh7FFFFFFF;
        else if (total < -34'sh80000000) sat = -32'sh80000000;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.finish) begin
            r_oval <= r_bad ? 32'sd0 : sat;
            r_oerr <= r_bad;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_out_value   = r_oval;
    assign o_range_error = r_oerr;

endmodule

>>> sv/conv2d_padded_strided.sv
// Padded, strided 2-D convolution of one output point per compute beat.
// Write beats load pixels, weights and biases into internal stores and are
// taken without a stall while idle. A compute beat walks all
// input_channels*kernel_height*kernel_width taps of its window, issuing one
// tap per cycle through a single multiply-accumulate, then adds the bias and
// saturates. The result sits in an output register; a position outside the
// output map returns zero with range_error set. Configuration writes are
// accepted at any time but must only be issued while the block is idle.
module conv2d_padded_strided (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_req_type,
    input  logic [11:0]         i_index,
    input  logic [2:0]          i_out_channel,
    input  logic [4:0]          i_out_row,
    input  logic [4:0]          i_out_col,
    input  logic signed [31:0]  i_data_value,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [31:0]  o_out_value,
    output logic                o_range_error
);
    import c2d_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    // Configuration registers, saturated into range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.img_h  <= 6'd32;
            r_cfg.img_w  <= 6'd32;
            r_cfg.in_ch  <= 3'd1;
            r_cfg.ker_h  <= 3'd3;
            r_cfg.ker_w  <= 3'd3;
            r_cfg.stride <= 3'd1;
            r_cfg.pad_r  <= 3'd0;
            r_cfg.pad_c  <= 3'd0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IMG_H:  r_cfg.img_h  <= clamp_val(i_cfg_data[5:0], 6'd1, 6'(MAX_HEIGHT));
                CFG_IMG_W:  r_cfg.img_w  <= clamp_val(i_cfg_data[5:0], 6'd1, 6'(MAX_WIDTH));
                CFG_IN_CH:  r_cfg.in_ch  <= 3'(clamp_val({3'd0, i_cfg_data[2:0]}, 6'd1,
                                               6'(MAX_IN_CHANNELS)));
                CFG_KER_H:  r_cfg.ker_h  <= 3'(clamp_val({3'd0, i_cfg_data[2:0]}, 6'd1,
                                               6'(MAX_KERNEL)));
                CFG_KER_W:  r_cfg.ker_w  <= 3'(clamp_val({3'd0, i_cfg_data[2:0]}, 6'd1,
                                               6'(MAX_KERNEL)));
                CFG_STRIDE: r_cfg.stride <= 3'(clamp_val({3'd0, i_cfg_data[2:0]}, 6'd1, 6'd4));
                CFG_PAD_R:  r_cfg.pad_r  <= 3'(clamp_val({3'd0, i_cfg_data[2:0]}, 6'd0, 6'd4));
                CFG_PAD_C:  r_cfg.pad_c  <= 3'(clamp_val({3'd0, i_cfg_data[2:0]}, 6'd0, 6'd4));
                default: ;
            endcase
        end
    end

    c2d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    c2d_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd         (cmd),
        .i_req_type    (i_req_type),
        .i_index       (i_index),
        .i_out_channel (i_out_channel),
        .i_out_row     (i_out_row),
        .i_out_col     (i_out_col),
        .i_data_value  (i_data_value),
        .i_out_stall   (i_out_stall),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .o_out_value   (o_out_value),
        .o_range_error (o_range_error)
    );

endmodule
